// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scr_pkg.sv =====
// Shared constants and types of the segment capacity reservation block.
package scr_pkg;

  localparam int unsigned SEGMENTS  = 2048;
  localparam int unsigned SEG_IDX_W = $clog2(SEGMENTS);
  localparam int unsigned POINT_W   = 11;
  localparam int unsigned PTR_W     = ((SEG_IDX_W + 1) > (POINT_W + 1)) ?
                                      (SEG_IDX_W + 1) : (POINT_W + 1);
  localparam int unsigned AMOUNT_W  = 16;
  localparam int unsigned LOAD_W    = 16;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned TOTAL_W   = 32;

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Register index taken from paddr[PADDR_W-1:2].
  localparam logic [PADDR_W-3:0] CFG_IDX_CAPACITY = '0;

  typedef struct packed {
    logic                 rd_en;
    logic [SEG_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [SEG_IDX_W-1:0] wr_addr;
    logic [LOAD_W-1:0]    wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [AMOUNT_W-1:0] granted;
    logic [TOTAL_W-1:0]  total;
  } result_t;

endpackage

// ===== rtl/scr_load_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module scr_load_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/scr_cfg_regs.sv =====
// APB-style configuration register holding the segment capacity.
module scr_cfg_regs
  import scr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CAP_W-1:0]   capacity_o
);

  logic [CAP_W-1:0] capacity_q;
  logic             hit_cap;

  assign hit_cap = (paddr[PADDR_W-1:2] == CFG_IDX_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (psel && penable && pwrite && hit_cap) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata     = (psel && hit_cap) ? PDATA_W'(capacity_q) : '0;
  assign pready     = 1'b1;
  assign capacity_o = capacity_q;

endmodule

// ===== rtl/scr_engine.sv =====
// Sequencer: clearing sweep, least-room scan, load update and result hand-off.
module scr_engine
  import scr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CAP_W-1:0]    capacity_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [POINT_W-1:0]  from_point_i,
  input  logic [POINT_W-1:0]  to_point_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  input  logic                last_request_i,
  output mem_req_t            mem_req_o,
  input  logic [LOAD_W-1:0]   mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output result_t             res_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [PTR_W-1:0]     lo_q, lo_d;
  logic [PTR_W-1:0]     hi_q, hi_d;
  logic [AMOUNT_W-1:0]  grant_q, grant_d;
  logic                 last_q, last_d;
  logic                 pend_q, pend_d;
  logic [SEG_IDX_W-1:0] wr_addr_q, wr_addr_d;
  logic [TOTAL_W-1:0]   sum_q, sum_d;

  logic [PTR_W-1:0]     in_lo, in_hi_raw, in_hi;
  logic                 ptr_in_range;
  logic                 load_full;
  logic [LOAD_W-1:0]    room;
  logic [TOTAL_W:0]     sum_ext;
  logic [TOTAL_W-1:0]   sum_next;
  logic                 scan_issue;

  assign in_lo        = PTR_W'(from_point_i);
  assign in_hi_raw    = PTR_W'(to_point_i);
  assign in_hi        = (in_hi_raw > PTR_W'(SEGMENTS)) ? PTR_W'(SEGMENTS) : in_hi_raw;
  assign ptr_in_range = (ptr_q < hi_q);
  assign load_full    = (mem_rdata_i >= capacity_i);
  assign room         = capacity_i - mem_rdata_i;
  assign scan_issue   = ptr_in_range && (grant_q != '0);

  // A zero grant leaves the total unchanged, so a full range needs no special case.
  assign sum_ext  = {1'b0, sum_q} + (TOTAL_W + 1)'(grant_q);
  assign sum_next = sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    grant_d   = grant_q;
    last_d    = last_q;
    pend_d    = 1'b0;
    wr_addr_d = wr_addr_q;
    sum_d     = sum_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    mem_req_o.rd_en   = 1'b0;
    mem_req_o.rd_addr = ptr_q[SEG_IDX_W-1:0];
    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = wr_addr_q;
    mem_req_o.wr_data = mem_rdata_i + grant_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = ptr_q[SEG_IDX_W-1:0];
        mem_req_o.wr_data = '0;
        ptr_d             = ptr_q + 1'b1;
        if (ptr_q == PTR_W'(SEGMENTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          lo_d    = in_lo;
          hi_d    = in_hi;
          ptr_d   = in_lo;
          grant_d = amount_i;
          last_d  = last_request_i;
          state_d = (in_lo >= in_hi) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          mem_req_o.rd_en = 1'b1;
          ptr_d           = ptr_q + 1'b1;
          pend_d          = 1'b1;
        end
        if (pend_q) begin
          if (load_full) begin
            grant_d = '0;
          end else if (room < grant_q) begin
            grant_d = room;
          end
        end
        if (!pend_q && !scan_issue) begin
          if (grant_q == '0) begin
            state_d = ST_EMIT;
          end else begin
            ptr_d   = lo_q;
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (ptr_in_range) begin
          mem_req_o.rd_en = 1'b1;
          ptr_d           = ptr_q + 1'b1;
          pend_d          = 1'b1;
          wr_addr_d       = ptr_q[SEG_IDX_W-1:0];
        end
        if (pend_q) begin
          mem_req_o.wr_en = 1'b1;
        end
        if (!pend_q && !ptr_in_range) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          sum_d = sum_next;
          if (last_q) begin
            sum_d   = '0;
            ptr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        ptr_d   = '0;
      end
    endcase
  end

  assign res_o.granted = grant_q;
  assign res_o.total   = sum_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      sum_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      grant_q   <= '0;
      last_q    <= 1'b0;
      wr_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      sum_q     <= sum_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      grant_q   <= grant_d;
      last_q    <= last_d;
      wr_addr_q <= wr_addr_d;
    end
  end

endmodule

// ===== rtl/segment_capacity_reservation_core.sv =====
// Top level of the segment capacity reservation block.
// Greedy admission over a row of 2048 segments that share one capacity
// limit (segment_capacity, register 0 at byte address 0). Each request
// transfer names a range [from_point, to_point) and an amount; the block
// grants the smaller of the amount and the least free room in the range,
// or zero when any segment in the range is full, adds the grant to every
// segment of the range and returns the grant with the saturating running
// total. An empty range grants the whole amount. Requests must already be
// sorted by end point. One request is in work at a time: both the scan
// for the least room and the load update walk the range one entry per
// cycle through the single read port of the load memory; the update is
// skipped when the grant is zero, and the scan stops early when a full
// segment turns up. After reset, and after every request flagged
// last_request, a clearing pass zeroes all 2048 entries of the load
// memory; no request is taken during it, configuration writes are. The
// result sits in an output register, so the next request may be taken
// while a result still waits for its transfer.
module segment_capacity_reservation_core
  import scr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [POINT_W-1:0]  from_point_i,
  input  logic [POINT_W-1:0]  to_point_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  input  logic                last_request_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [AMOUNT_W-1:0] granted_o,
  output logic [TOTAL_W-1:0]  total_granted_o
);

  logic [CAP_W-1:0]  capacity;
  mem_req_t          mem_req;
  logic [LOAD_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  logic                out_valid_q, out_valid_d;
  logic [AMOUNT_W-1:0] granted_q;
  logic [TOTAL_W-1:0]  total_q;

  scr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // Per-segment load store; contents are only trusted after a clearing pass.
  scr_load_ram #(
    .Depth (SEGMENTS),
    .Width (LOAD_W)
  ) u_load_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_req.wr_en),
    .wr_addr_i (mem_req.wr_addr),
    .wr_data_i (mem_req.wr_data),
    .rd_en_i   (mem_req.rd_en),
    .rd_addr_i (mem_req.rd_addr),
    .rd_data_o (mem_rdata)
  );

  scr_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capacity_i     (capacity),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .from_point_i   (from_point_i),
    .to_point_i     (to_point_i),
    .amount_i       (amount_i),
    .last_request_i (last_request_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // Output register: take a new result when empty or when the held one
  // leaves in this cycle, otherwise hold.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      granted_q <= res.granted;
      total_q   <= res.total;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign total_granted_o = total_q;

endmodule

// ===== rtl/scr_checker.sv =====
// Port-level checker for the segment capacity reservation top level, with its bind.
`include "assert_macros.svh"

module scr_checker
  import scr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [AMOUNT_W-1:0] granted_o,
  input logic [TOTAL_W-1:0]  total_granted_o
);

  // A stalled result stays offered.
  `SCR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload.
  `SCR_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(granted_o) && $stable(total_granted_o), "result changed while stalled")

  // The running total always includes the grant it is reported with.
  `SCR_ASSERT_IMP(a_total_covers, out_valid_o, total_granted_o >= TOTAL_W'(granted_o), "total below grant")

  // One request at a time: a request transfer closes the input for the next cycle.
  `SCR_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

endmodule

bind segment_capacity_reservation_core scr_checker u_scr_checker (.*);

// ===== tb/scr_grant_checker.sv =====
// Grant checker: tracks segment loads and batch total, checks every result and capacity read.
module scr_grant_checker
  import scr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  input  logic [PDATA_W-1:0]  prdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [POINT_W-1:0]  from_point_i,
  input  logic [POINT_W-1:0]  to_point_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  input  logic                last_request_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [AMOUNT_W-1:0] granted_i,
  input  logic [TOTAL_W-1:0]  total_granted_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LOAD_W-1:0]  seg_load [SEGMENTS];
  logic [TOTAL_W-1:0] batch_total;
  logic [CAP_W-1:0]   capacity;
  result_t            grants_due [$];
  int unsigned        mismatches = 0;

  function automatic void empty_row();
    foreach (seg_load[i]) seg_load[i] = '0;
    batch_total = '0;
  endfunction

  // Greedy admission: least room over [lo, hi), zero if any segment is full.
  function automatic result_t reserve(input logic [POINT_W-1:0] lo,
                                      input logic [POINT_W-1:0] hi,
                                      input logic [AMOUNT_W-1:0] amt);
    result_t             res;
    logic [AMOUNT_W-1:0] grant;
    bit                  blocked;
    int unsigned         stop;
    grant   = amt;
    blocked = 1'b0;
    stop    = (hi > SEGMENTS) ? SEGMENTS : hi;
    for (int unsigned i = lo; i < stop; i++) begin
      if (seg_load[i] >= capacity) begin
        blocked = 1'b1;
        break;
      end
      if (grant > capacity - seg_load[i]) grant = capacity - seg_load[i];
    end
    if (blocked) begin
      grant = '0;
    end else begin
      for (int unsigned i = lo; i < stop; i++) seg_load[i] = seg_load[i] + grant;
      if (TOTAL_W'(grant) > ~batch_total) batch_total = '1;
      else batch_total = batch_total + TOTAL_W'(grant);
    end
    res.granted = grant;
    res.total   = batch_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      empty_row();
      capacity = '0;
      grants_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[PADDR_W-1:2] == CFG_IDX_CAPACITY) capacity = pwdata[CAP_W-1:0];
        end else if (prdata !== PDATA_W'(capacity)) begin
          $error("prdata: expected %0d, got %0d", capacity, prdata);
          mismatches++;
        end
      end
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          $error("result with none due: granted %0d, total_granted %0d",
                 granted_i, total_granted_i);
          mismatches++;
        end else begin
          due = grants_due.pop_front();
          if (granted_i !== due.granted) begin
            $error("granted: expected %0d, got %0d", due.granted, granted_i);
            mismatches++;
          end
          if (total_granted_i !== due.total) begin
            $error("total_granted: expected %0d, got %0d", due.total, total_granted_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        grants_due.push_back(reserve(from_point_i, to_point_i, amount_i));
        if (last_request_i) empty_row();
      end
    end
    pending_o    = grants_due.size();
    mismatches_o = mismatches;
  end

endmodule

// ===== tb/segment_capacity_reservation_core_test.sv =====
// Top of the segment capacity reservation testbench: clock, reset, stimulus and verdict.
module segment_capacity_reservation_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scr_pkg::*;

  // Slowest correct gap between transfers is a whole-row request or a clearing pass;
  // allow several times that.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 5000;
  localparam int unsigned PHASE_ITEMS = 41;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [PDATA_W-1:0]  pwdata         = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [POINT_W-1:0]  from_point_i   = '0;
  logic [POINT_W-1:0]  to_point_i     = '0;
  logic [AMOUNT_W-1:0] amount_i       = '0;
  logic                last_request_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [AMOUNT_W-1:0] granted_o;
  logic [TOTAL_W-1:0]  total_granted_o;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 70;
  int unsigned stall_count   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  segment_capacity_reservation_core i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .from_point_i,
    .to_point_i,
    .amount_i,
    .last_request_i,
    .out_valid_o,
    .out_ready_i,
    .granted_o,
    .total_granted_o
  );

  scr_grant_checker i_grant_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .from_point_i,
    .to_point_i,
    .amount_i,
    .last_request_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .granted_i       (granted_o),
    .total_granted_i (total_granted_o),
    .pending_o       (pending_results),
    .mismatches_o    (mismatch_count)
  );

  // Receiver: stall at random at the current rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: end the run when nothing has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Offer one request and hold it until the transfer. Valid stays high into the
  // next request unless the sender chooses to idle first.
  task automatic push_request(input logic [POINT_W-1:0] lo, input logic [POINT_W-1:0] hi,
                              input logic [AMOUNT_W-1:0] amt, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    from_point_i   <= lo;
    to_point_i     <= hi;
    amount_i       <= amt;
    last_request_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic hold_requests();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sample the outstanding count away from the active edge.
  task automatic wait_drained();
    do @(negedge clk_i); while (pending_results != 0);
    @(posedge clk_i);
  endtask

  // Setup cycle then access cycle; the checker compares prdata on reads.
  task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {CFG_IDX_CAPACITY, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Change the capacity only with nothing in flight; junk in the upper bits must be dropped.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    hold_requests();
    wait_drained();
    apb_access(1'b1, {16'($urandom), cap});
    apb_access(1'b0, '0);
  endtask

  // Batches sorted by end point with random spans and amounts, plus some unsorted noise.
  task automatic run_batches(input int unsigned quota);
    int unsigned         sent;
    int unsigned         cursor;
    int unsigned         batch_len;
    int unsigned         hi_pt;
    int unsigned         lo_pt;
    int unsigned         span;
    int unsigned         pick;
    logic [AMOUNT_W-1:0] amt;
    sent = 0;
    while (sent < quota) begin
      cursor    = $urandom_range(0, 200);
      batch_len = $urandom_range(1, 12);
      if (batch_len > quota - sent) batch_len = quota - sent;
      for (int unsigned k = 0; k < batch_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          hi_pt = $urandom_range(0, 2047);
          lo_pt = $urandom_range(0, 2047);
        end else begin
          cursor = cursor + $urandom_range(0, 40);
          if (cursor > 2047) cursor = 2047;
          hi_pt = cursor;
          // keep most ranges short: each segment is walked by both the scan and the update
          pick = $urandom_range(0, 99);
          if (pick < 85) span = $urandom_range(0, 16);
          else if (pick < 95) span = $urandom_range(17, 256);
          else span = $urandom_range(257, 2047);
          lo_pt = (span >= hi_pt) ? 0 : hi_pt - span;
        end
        amt = $urandom_range(0, 1) ? AMOUNT_W'($urandom) : AMOUNT_W'($urandom_range(0, 64));
        push_request(POINT_W'(lo_pt), POINT_W'(hi_pt), amt, k == batch_len - 1);
        sent++;
      end
      // now and then let every result come home before going on
      if ($urandom_range(0, 4) == 0) begin
        hold_requests();
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // capacity must read back as zero after reset
    apb_access(1'b0, '0);
    // zero capacity: every segment is full, only an empty range grants
    push_request(11'd5, 11'd9, 16'd100, 1'b0);
    push_request(11'd3, 11'd3, 16'hFFFF, 1'b0);
    push_request(11'd2047, 11'd0, 16'h5555, 1'b0);

    set_capacity(16'd1000);
    push_request(11'd10, 11'd20, 16'd600, 1'b0);
    // overlap: least room in the range limits the grant
    push_request(11'd15, 11'd25, 16'd600, 1'b0);
    push_request(11'd12, 11'd14, 16'd0, 1'b0);
    // whole row crosses full segments: nothing granted, total unchanged
    push_request(11'd0, 11'd2047, 16'hAAAA, 1'b0);

    // drop the capacity below loads already carried
    set_capacity(16'd500);
    push_request(11'd10, 11'd11, 16'd5, 1'b0);
    push_request(11'd20, 11'd26, 16'd200, 1'b0);
    push_request(11'd25, 11'd30, 16'hFFFF, 1'b0);
    push_request(11'd1024, 11'd2047, 16'd1, 1'b1);

    set_capacity(16'hFFFF);
    push_request(11'd0, 11'd2047, 16'hFFFF, 1'b0);
    push_request(11'd2046, 11'd2047, 16'd1, 1'b0);
    push_request(11'd0, 11'd0, 16'hFFFF, 1'b0);
    push_request(11'd1, 11'd2, 16'd1, 1'b1);
    // loads were cleared by the batch end, so these fit again
    push_request(11'd0, 11'd1, 16'h8000, 1'b0);
    push_request(11'd0, 11'd2047, 16'd0, 1'b1);

    // sender light, receiver heavy
    set_capacity(16'($urandom_range(64, 4000)));
    run_batches(PHASE_ITEMS);

    // sender heavy, receiver light; tiny capacity fills segments quickly
    send_idle_pct = 70;
    recv_idle_pct = 13;
    set_capacity(16'($urandom_range(1, 40)));
    run_batches(PHASE_ITEMS);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(16'($urandom_range(1000, 65535)));
    run_batches(PHASE_ITEMS);

    hold_requests();
    wait_drained();
    // watch for stray results a full-row request and a clearing pass could hide
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
